// File: hw/rtl/tmcr_pkg.sv
package tmcr_pkg;

  // Default geometry
  localparam int CELLS_DEF       = 2400;
  localparam int GLYPH_LINES_DEF = 16;

  // Field widths of the stream payload
  localparam int CELL_W  = 12;
  localparam int LINE_W  = 4;
  localparam int BYTE_W  = 8;
  localparam int PIX_W   = 64;
  localparam int KIND_W  = 2;

  // Input item kinds
  localparam logic [KIND_W-1:0] KIND_BUS_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BUS_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RENDER    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FONT_LOAD = 2'd3;

  // Bus registers
  localparam logic [BYTE_W-1:0] REG_CHAR = 8'd0;
  localparam logic [BYTE_W-1:0] REG_ATTR = 8'd1;
  localparam logic [BYTE_W-1:0] REG_CTRL = 8'd3;

  // Control value that homes the cursor
  localparam logic [BYTE_W-1:0] CTRL_HOME = 8'd10;

  // Result kinds
  localparam logic RES_READ  = 1'b0;
  localparam logic RES_PIXEL = 1'b1;

  // Back-end operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_WCHAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_WATTR  = 3'd1;
  localparam logic [OP_W-1:0] OP_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_RENDER = 3'd3;
  localparam logic [OP_W-1:0] OP_RZERO  = 3'd4;
  localparam logic [OP_W-1:0] OP_FONT   = 3'd5;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CELL_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] code;
    logic [LINE_W-1:0] line;
  } cmd_t;

endpackage

// File: hw/rtl/tmcr_front.sv
module tmcr_front #(
  parameter int CELLS       = tmcr_pkg::CELLS_DEF,
  parameter int GLYPH_LINES = tmcr_pkg::GLYPH_LINES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,
  input  logic [1:0]          s_tuser,
  input  logic                q_full,
  input  logic                clearing,
  output logic                push,
  output tmcr_pkg::cmd_t      push_cmd
);

  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [AW-1:0] cursor;
  logic [AW-1:0] cursor_next;
  logic [AW-1:0] prev_cell;
  logic [7:0]    bus_reg;
  logic [7:0]    value;
  logic [11:0]   cell_index;
  logic [3:0]    glyph_line;
  logic [7:0]    glyph_code;
  logic          accept;
  logic          cell_bad;
  logic          line_bad;

  // Unpack the item
  assign bus_reg    = s_tdata[7:0];
  assign value      = s_tdata[15:8];
  assign cell_index = s_tdata[27:16];
  assign glyph_line = s_tdata[31:28];
  assign glyph_code = s_tdata[39:32];

  assign s_tready = !clearing && !q_full;
  assign accept   = s_tvalid && s_tready;

  assign prev_cell = (cursor != '0) ? cursor - AW'(1) : AW'(CELLS - 1);
  assign cell_bad  = {1'b0, cell_index} >= 13'(CELLS);
  assign line_bad  = {1'b0, glyph_line} >= 5'(GLYPH_LINES);

  // Classify the item into a back-end command and the next cursor
  always_comb begin
    push          = 1'b0;
    cursor_next   = cursor;
    push_cmd.op   = tmcr_pkg::OP_RZERO;
    push_cmd.addr = cell_index;
    push_cmd.data = value;
    push_cmd.code = glyph_code;
    push_cmd.line = glyph_line;
    case (s_tuser)
      tmcr_pkg::KIND_BUS_WRITE: begin
        if (bus_reg == tmcr_pkg::REG_CHAR) begin
          push          = accept;
          push_cmd.op   = tmcr_pkg::OP_WCHAR;
          push_cmd.addr = 12'(cursor);
          cursor_next   = (cursor == AW'(CELLS - 1)) ? '0 : cursor + AW'(1);
        end else if (bus_reg == tmcr_pkg::REG_ATTR) begin
          push          = accept;
          push_cmd.op   = tmcr_pkg::OP_WATTR;
          push_cmd.addr = 12'(prev_cell);
        end else if (bus_reg == tmcr_pkg::REG_CTRL) begin
          if (value == tmcr_pkg::CTRL_HOME) begin
            cursor_next = '0;
          end
        end
      end
      tmcr_pkg::KIND_BUS_READ: begin
        push          = accept;
        push_cmd.op   = tmcr_pkg::OP_READ;
        push_cmd.addr = 12'(prev_cell);
      end
      tmcr_pkg::KIND_RENDER: begin
        push        = accept;
        push_cmd.op = (cell_bad || line_bad) ? tmcr_pkg::OP_RZERO : tmcr_pkg::OP_RENDER;
      end
      default: begin
        push        = accept && !line_bad;
        push_cmd.op = tmcr_pkg::OP_FONT;
      end
    endcase
  end

  // Advance the cursor on accepted items
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (accept) begin
      cursor <= cursor_next;
    end
  end

endmodule

// File: hw/rtl/tmcr_queue.sv
module tmcr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tmcr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tmcr_pkg::cmd_t head
);

  tmcr_pkg::cmd_t                entries [tmcr_pkg::QUEUE_DEPTH];
  logic [tmcr_pkg::QPTR_W-1:0]   wr_ptr;
  logic [tmcr_pkg::QPTR_W-1:0]   rd_ptr;
  logic [tmcr_pkg::QPTR_W:0]     count;

  assign full  = count == (tmcr_pkg::QPTR_W + 1)'(tmcr_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tmcr_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tmcr_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (tmcr_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (tmcr_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: hw/rtl/tmcr_back.sv
module tmcr_back #(
  parameter int CELLS       = tmcr_pkg::CELLS_DEF,
  parameter int GLYPH_LINES = tmcr_pkg::GLYPH_LINES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  tmcr_pkg::cmd_t head,
  output logic           pop,
  output logic           clearing,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [71:0]    m_tdata,
  output logic [0:0]     m_tuser
);

  localparam int AW         = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int LW         = $clog2(GLYPH_LINES);
  localparam int FW         = 8 + LW;
  localparam int FONT_DEPTH = 256 << LW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD1   = 3'd2;
  localparam logic [2:0] ST_RD2   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [7:0] char_mem [CELLS];
  logic [7:0] attr_mem [CELLS];
  logic [7:0] font_mem [FONT_DEPTH];

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          char_we;
  logic          attr_we;
  logic          cell_re;
  logic          font_we;
  logic          font_re;
  logic [FW-1:0] font_waddr;
  logic [FW-1:0] font_raddr;
  logic [7:0]    char_rd;
  logic [7:0]    attr_rd;
  logic [7:0]    font_rd;
  logic [2:0]    op_q;
  logic [3:0]    line_q;
  logic          load_read;
  logic          load_pix;
  logic          load_zero;
  logic          out_kind;
  logic [7:0]    out_read;
  logic [63:0]   out_pix;

  // Map a 4-bit colour index to an 8-bit colour
  function automatic logic [7:0] palette(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:                    c = 8'h00;
      4'd15:                   c = 8'hFF;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13: c = 8'hC0;
      4'd2, 4'd5, 4'd8, 4'd11, 4'd14: c = 8'h38;
      default:                 c = 8'h02;
    endcase
    return c;
  endfunction

  // Expand one glyph row into eight colour bytes
  function automatic logic [63:0] expand(input logic [7:0] row, input logic [7:0] attr);
    logic [7:0]  fg;
    logic [7:0]  bg;
    logic [63:0] px;
    fg = (attr != 8'h00) ? palette(attr[3:0]) : 8'hFF;
    bg = (attr != 8'h00) ? palette(attr[7:4]) : 8'h00;
    for (int k = 0; k < 8; k++) begin
      px[8*k +: 8] = row[7-k] ? fg : bg;
    end
    return px;
  endfunction

  assign clearing   = state == ST_CLEAR;
  assign font_waddr = {head.code, head.line[LW-1:0]};
  assign font_raddr = {char_rd, line_q[LW-1:0]};

  // Sequence one command at a time
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    char_we    = 1'b0;
    attr_we    = 1'b0;
    cell_re    = 1'b0;
    font_we    = 1'b0;
    font_re    = 1'b0;
    load_read  = 1'b0;
    load_pix   = 1'b0;
    load_zero  = 1'b0;
    wr_addr    = head.addr[AW-1:0];
    wr_data    = head.data;
    case (state)
      ST_CLEAR: begin
        char_we = 1'b1;
        attr_we = 1'b1;
        wr_addr = clr_addr;
        wr_data = 8'h00;
        if (clr_addr == AW'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          case (head.op)
            tmcr_pkg::OP_WCHAR: char_we = 1'b1;
            tmcr_pkg::OP_WATTR: attr_we = 1'b1;
            tmcr_pkg::OP_FONT:  font_we = 1'b1;
            tmcr_pkg::OP_READ, tmcr_pkg::OP_RENDER: begin
              cell_re    = 1'b1;
              state_next = ST_RD1;
            end
            default: begin
              load_zero  = 1'b1;
              state_next = ST_OUT;
            end
          endcase
        end
      end
      ST_RD1: begin
        if (op_q == tmcr_pkg::OP_READ) begin
          load_read  = 1'b1;
          state_next = ST_OUT;
        end else begin
          font_re    = 1'b1;
          state_next = ST_RD2;
        end
      end
      ST_RD2: begin
        load_pix   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state, clear sweep address and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (load_read || load_pix || load_zero) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Latch the command being worked on
  always_ff @(posedge clk) begin
    if (pop) begin
      op_q   <= head.op;
      line_q <= head.line;
    end
  end

  // Character store
  always_ff @(posedge clk) begin
    if (char_we) begin
      char_mem[wr_addr] <= wr_data;
    end
    if (cell_re) begin
      char_rd <= char_mem[head.addr[AW-1:0]];
    end
  end

  // Attribute store
  always_ff @(posedge clk) begin
    if (attr_we) begin
      attr_mem[wr_addr] <= wr_data;
    end
    if (cell_re) begin
      attr_rd <= attr_mem[head.addr[AW-1:0]];
    end
  end

  // Font store
  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[font_waddr] <= head.data;
    end
    if (font_re) begin
      font_rd <= font_mem[font_raddr];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_read) begin
      out_kind <= tmcr_pkg::RES_READ;
      out_read <= char_rd;
      out_pix  <= '0;
    end else if (load_pix) begin
      out_kind <= tmcr_pkg::RES_PIXEL;
      out_read <= '0;
      out_pix  <= expand(font_rd, attr_rd);
    end else if (load_zero) begin
      out_kind <= tmcr_pkg::RES_PIXEL;
      out_read <= '0;
      out_pix  <= '0;
    end
  end

  assign m_tdata = {out_pix, out_read};
  assign m_tuser = out_kind;

endmodule

// File: hw/rtl/text_mode_cell_renderer_core.sv
// Text-mode cell renderer: 80x30 character and attribute stores, loadable font.
// Input stream (s_*): one item per handshake. s_tuser is the item kind (bus write,
// bus read, render, font row load); s_tdata carries bus register, value, cell index,
// glyph line and glyph code. Output stream (m_*): bus read data or eight pixel
// bytes; m_tuser marks which.
// The front accepts up to one item per cycle, while the queue has room and the
// stores are not being cleared, into a four-entry command queue and keeps the
// write cursor, so ignored writes and cursor updates never enter the queue. The
// back drains the queue one command at a time over single-port stores: a store
// write or font load is done from the idle state, a bus read passes a registered
// char/attr read and the output register, a render a registered char/attr read,
// a registered font read and the output register; the result then waits until
// it is taken. A render outside the screen or glyph skips the store reads and
// loads a zero result. Sustained rate is set by the back, which takes a new
// command only when idle. After reset the back sweeps all CELLS entries (2400
// by default) of both stores to zero, with s_tready low. The font store is not
// cleared. When m_tready is low the result is held; the front keeps filling the
// queue until it is full, then drops s_tready.
module text_mode_cell_renderer_core #(
  parameter int CELLS       = tmcr_pkg::CELLS_DEF,
  parameter int GLYPH_LINES = tmcr_pkg::GLYPH_LINES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // bus_reg, value, cell_index, glyph_line, glyph_code
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // read_data, pixels
  output logic [0:0]  m_tuser    // result_kind
);

  logic           q_full;
  logic           q_empty;
  logic           clearing;
  logic           push;
  logic           pop;
  tmcr_pkg::cmd_t push_cmd;
  tmcr_pkg::cmd_t head;

  tmcr_front #(
    .CELLS       (CELLS),
    .GLYPH_LINES (GLYPH_LINES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tmcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  tmcr_back #(
    .CELLS       (CELLS),
    .GLYPH_LINES (GLYPH_LINES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (q_empty),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: hw/rtl/tmcr_checker.sv
module tmcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // Input is refused as the clearing sweep of the stores starts after reset
  a_clear_blocks_input: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input accepted during clearing sweep");

  // No result is offered right after reset
  a_reset_drops_output: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // The field not belonging to the result kind is zero
  a_unused_field_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] ? (m_tdata[7:0] == 8'h00) : (m_tdata[71:8] == 64'h0)))
    else $error("unused result field not zero");

endmodule

bind text_mode_cell_renderer_core tmcr_checker u_tmcr_checker (.*);
